// ===== design/multi_seat_occupancy_debouncer_top_assert.svh =====
// assertion macros used by the occupancy debouncer checker
`ifndef MULTI_SEAT_OCCUPANCY_DEBOUNCER_TOP_ASSERT_SVH
`define MULTI_SEAT_OCCUPANCY_DEBOUNCER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define MSOD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define MSOD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/msod_pkg.sv =====
// package: widths, register codes, result types and percentage function
package msod_pkg;

    localparam int SEAT_COUNT   = 5;
    localparam int SCAN_SEATS   = 5;
    localparam int SEAT_DIVISOR = (SEAT_COUNT > 0) ? SEAT_COUNT : 1;
    localparam int FULL_PERCENT = 100;

    localparam int DIST_W     = 10;
    localparam int CNT_W      = 8;
    localparam int TOTAL_W    = 3;
    localparam int PCT_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [DIST_W-1:0] NEAR_RESET = 10'd250;
    localparam logic [CNT_W-1:0]  HOLD_RESET = 8'd5;
    localparam logic [CNT_W-1:0]  CNT_MAX    = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEAR_THRESHOLD = 2'd0,
        CFG_HOLD_COUNT     = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic [DIST_W-1:0] near_threshold;
        logic [CNT_W-1:0]  hold_count;
    } t_cfg;

    typedef struct packed {
        logic [SCAN_SEATS-1:0] busy;
        logic [TOTAL_W-1:0]    total;
        logic [PCT_W-1:0]      percent;
    } t_result;

    // total * 100 / seat count, truncated, capped at 100, as a constant table
    function automatic logic [PCT_W-1:0] pct_of(input logic [TOTAL_W-1:0] total);
        int p;
        case (total)
            3'd0:    p = 0;
            3'd1:    p = 1 * FULL_PERCENT / SEAT_DIVISOR;
            3'd2:    p = 2 * FULL_PERCENT / SEAT_DIVISOR;
            3'd3:    p = 3 * FULL_PERCENT / SEAT_DIVISOR;
            3'd4:    p = 4 * FULL_PERCENT / SEAT_DIVISOR;
            3'd5:    p = 5 * FULL_PERCENT / SEAT_DIVISOR;
            3'd6:    p = 6 * FULL_PERCENT / SEAT_DIVISOR;
            3'd7:    p = 7 * FULL_PERCENT / SEAT_DIVISOR;
            default: p = 0;
        endcase
        if (p > FULL_PERCENT) begin
            p = FULL_PERCENT;
        end
        return p[PCT_W-1:0];
    endfunction

endpackage

// ===== design/multi_seat_occupancy_debouncer_top.sv =====
// top level: five-seat occupancy debouncer with count and percentage
//
//  channel  direction  handshake                 payload
//  in       to block   i_in_valid / o_in_stall   i_seat0..4_distance
//  out      from block o_out_valid / i_out_stall o_seat0..4_busy, o_busy_total,
//                                                o_busy_percent
//  cfg      to block   i_cfg_wr_en               i_cfg_index, i_cfg_wdata
//
// one scan per cycle while o_in_stall is low; a result is registered in the output buffer once its scan is accepted
// all five seat lanes update in the same cycle, the merge stage counts them
// a two-entry output buffer keeps full rate while the output is not stalled
// o_in_stall rises only once both output entries hold unread results
// synchronous reset clears counters, flags, valid bits and config to defaults
module multi_seat_occupancy_debouncer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [msod_pkg::DIST_W-1:0]       i_seat0_distance,
    input  logic [msod_pkg::DIST_W-1:0]       i_seat1_distance,
    input  logic [msod_pkg::DIST_W-1:0]       i_seat2_distance,
    input  logic [msod_pkg::DIST_W-1:0]       i_seat3_distance,
    input  logic [msod_pkg::DIST_W-1:0]       i_seat4_distance,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_seat0_busy,
    output logic                              o_seat1_busy,
    output logic                              o_seat2_busy,
    output logic                              o_seat3_busy,
    output logic                              o_seat4_busy,
    output logic [msod_pkg::TOTAL_W-1:0]      o_busy_total,
    output logic [msod_pkg::PCT_W-1:0]        o_busy_percent,
    input  logic                              i_cfg_wr_en,
    input  logic [msod_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [msod_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    msod_pkg::t_cfg    r_cfg;
    msod_pkg::t_result result;
    logic [msod_pkg::DIST_W-1:0]     seat_dist [msod_pkg::SCAN_SEATS];
    logic [msod_pkg::SCAN_SEATS-1:0] flags;
    logic                            accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_threshold <= msod_pkg::NEAR_RESET;
            r_cfg.hold_count     <= msod_pkg::HOLD_RESET;
        end else if (i_cfg_wr_en) begin
            case (msod_pkg::t_cfg_reg'(i_cfg_index))
                msod_pkg::CFG_NEAR_THRESHOLD: begin
                    r_cfg.near_threshold <= i_cfg_wdata[msod_pkg::DIST_W-1:0];
                end
                msod_pkg::CFG_HOLD_COUNT: begin
                    r_cfg.hold_count <= i_cfg_wdata[msod_pkg::CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign seat_dist[0] = i_seat0_distance;
    assign seat_dist[1] = i_seat1_distance;
    assign seat_dist[2] = i_seat2_distance;
    assign seat_dist[3] = i_seat3_distance;
    assign seat_dist[4] = i_seat4_distance;

    assign accept = i_in_valid && !o_in_stall;

    for (genvar s = 0; s < msod_pkg::SCAN_SEATS; s++) begin : g_lane
        msod_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (accept),
            .i_distance (seat_dist[s]),
            .i_cfg      (r_cfg),
            .o_flag     (flags[s])
        );
    end

    msod_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_flags     (flags),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_in_stall  (o_in_stall),
        .o_result    (result)
    );

    assign o_seat0_busy   = result.busy[0];
    assign o_seat1_busy   = result.busy[1];
    assign o_seat2_busy   = result.busy[2];
    assign o_seat3_busy   = result.busy[3];
    assign o_seat4_busy   = result.busy[4];
    assign o_busy_total   = result.total;
    assign o_busy_percent = result.percent;

endmodule

// ===== design/msod_lane.sv =====
// one seat lane: integrating counter and occupied flag
module msod_lane (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [msod_pkg::DIST_W-1:0]  i_distance,
    input  msod_pkg::t_cfg               i_cfg,
    output logic                         o_flag
);

    logic [msod_pkg::CNT_W-1:0] r_count;
    logic [msod_pkg::CNT_W-1:0] n_count;
    logic                       r_flag;
    logic                       n_flag;
    logic                       near;

    assign near = i_distance < i_cfg.near_threshold;

    always_comb begin
        if (near) begin
            n_count = (r_count == msod_pkg::CNT_MAX) ? r_count : r_count + 1'b1;
        end else if (r_count > i_cfg.hold_count) begin
            n_count = i_cfg.hold_count;
        end else if (r_count != '0) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end

        // between zero and hold the flag keeps its last value
        if (n_count >= i_cfg.hold_count) begin
            n_flag = 1'b1;
        end else if (n_count == '0) begin
            n_flag = 1'b0;
        end else begin
            n_flag = r_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_flag  <= 1'b0;
        end else if (i_en) begin
            r_count <= n_count;
            r_flag  <= n_flag;
        end
    end

    // flag as it stands after this transaction
    assign o_flag = n_flag;

endmodule

// ===== design/msod_merge.sv =====
// merge stage: seat count, percentage, output register and skid buffer
module msod_merge (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic [msod_pkg::SCAN_SEATS-1:0]   i_flags,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic                              o_in_stall,
    output msod_pkg::t_result                 o_result
);

    msod_pkg::t_result r_out;
    msod_pkg::t_result n_out;
    msod_pkg::t_result r_skid;
    msod_pkg::t_result n_skid;
    msod_pkg::t_result new_res;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              r_skid_valid;
    logic              n_skid_valid;
    logic              taken;
    logic [msod_pkg::TOTAL_W-1:0] total;

    always_comb begin
        total = '0;
        for (int s = 0; s < msod_pkg::SCAN_SEATS; s++) begin
            total = total + msod_pkg::TOTAL_W'(i_flags[s]);
        end
        new_res.busy    = i_flags;
        new_res.total   = total;
        new_res.percent = msod_pkg::pct_of(total);
    end

    assign taken = r_out_valid && !i_out_stall;

    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            // input is stalled while the skid entry is full
            if (taken) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_load) begin
            if (!r_out_valid || taken) begin
                n_out       = new_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = new_res;
                n_skid_valid = 1'b1;
            end
        end else if (taken) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid = r_out_valid;
    assign o_in_stall  = r_skid_valid;
    assign o_result    = r_out;

endmodule

// ===== design/msod_checker.sv =====
// port-level checker for the occupancy debouncer, bound to the top level
`include "multi_seat_occupancy_debouncer_top_assert.svh"

module msod_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic                              o_seat0_busy,
    input logic                              o_seat1_busy,
    input logic                              o_seat2_busy,
    input logic                              o_seat3_busy,
    input logic                              o_seat4_busy,
    input logic [msod_pkg::TOTAL_W-1:0]      o_busy_total,
    input logic [msod_pkg::PCT_W-1:0]        o_busy_percent
);

    logic [msod_pkg::TOTAL_W-1:0] flag_sum;
    logic                         in_xact;
    logic                         out_xact;

    assign flag_sum = msod_pkg::TOTAL_W'(o_seat0_busy) + msod_pkg::TOTAL_W'(o_seat1_busy)
                    + msod_pkg::TOTAL_W'(o_seat2_busy) + msod_pkg::TOTAL_W'(o_seat3_busy)
                    + msod_pkg::TOTAL_W'(o_seat4_busy);
    assign in_xact  = i_in_valid && !o_in_stall;
    assign out_xact = o_out_valid && !i_out_stall;

    `MSOD_ASSERT_NOW(a_total_matches_flags, o_out_valid, o_busy_total == flag_sum,
        "busy_total does not match the seat flags")

    `MSOD_ASSERT_NOW(a_percent_matches_total, o_out_valid,
        o_busy_percent == msod_pkg::pct_of(o_busy_total),
        "busy_percent does not match busy_total")

    `MSOD_ASSERT_NEXT(a_no_invented_result, !o_out_valid && !in_xact, !o_out_valid,
        "result appeared without an input transaction")

    `MSOD_ASSERT_NEXT(a_stalled_result_holds, o_out_valid && !out_xact,
        o_out_valid && $stable(o_busy_total) && $stable(o_busy_percent),
        "stalled result changed")

endmodule

bind multi_seat_occupancy_debouncer_top msod_checker u_msod_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_seat0_busy   (o_seat0_busy),
    .o_seat1_busy   (o_seat1_busy),
    .o_seat2_busy   (o_seat2_busy),
    .o_seat3_busy   (o_seat3_busy),
    .o_seat4_busy   (o_seat4_busy),
    .o_busy_total   (o_busy_total),
    .o_busy_percent (o_busy_percent)
);
